>>> src/mie_pkg.sv
// package for the modular inverse core
// holds the default width and the sequencer state type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

  localparam int unsigned WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } mie_state_t;

endpackage

`default_nettype wire

>>> src/mie_in_if.sv
// input channel of the modular inverse core: valid/ready and operands
// uses mie_pkg for the default width
`timescale 1ns / 1ps
`default_nettype none

interface mie_in_if #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [WIDTH-1:0]        modulus;
  logic signed [WIDTH:0]   value;

  modport source (output valid, output modulus, output value, input ready);
  modport sink   (input valid, input modulus, input value, output ready);
endinterface

`default_nettype wire

>>> src/mie_out_if.sv
// result channel of the modular inverse core: valid/ready and results
// uses mie_pkg for the default width
`timescale 1ns / 1ps
`default_nettype none

interface mie_out_if #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
);
  logic             valid;
  logic             ready;
  logic             invertible;
  logic [WIDTH-1:0] inverse;
  logic [WIDTH-1:0] negated_inverse;

  modport source (output valid, output invertible, output inverse,
                  output negated_inverse, input ready);
  modport sink   (input valid, input invertible, input inverse,
                  input negated_inverse, output ready);
endinterface

`default_nettype wire

>>> src/mie_div_unit.sv
// bit-serial restoring divider with a modular horner accumulator
// gives dividend % divisor and (quotient * mult) mod modulus; uses mie_pkg
`timescale 1ns / 1ps
`default_nettype none

module mie_div_unit #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH:0]   dividend,
  input  wire logic [WIDTH-1:0] divisor,
  input  wire logic [WIDTH-1:0] mult,
  input  wire logic [WIDTH-1:0] modulus,
  output logic                  done,
  output logic [WIDTH-1:0]      rem,
  output logic [WIDTH-1:0]      acc
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH:0]   dvd_r;
  logic [WIDTH-1:0] dsr_r;
  logic [WIDTH-1:0] mul_r;
  logic [WIDTH-1:0] mod_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] acc_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH+1:0] diff;
  logic             qbit;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH+1:0] hsum;
  logic [WIDTH+2:0] hsub1;
  logic [WIDTH+2:0] hsub2;
  logic [WIDTH-1:0] acc_nxt;
  logic             last;

  // one quotient bit per cycle, msb first
  always_comb begin
    rem_sh  = {rem_r, dvd_r[WIDTH]};
    diff    = {1'b0, rem_sh} - {2'b0, dsr_r};
    qbit    = ~diff[WIDTH+1];
    rem_nxt = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
  end

  // acc = 2*acc + qbit*mult, then bring below the modulus (sum stays under 3m)
  always_comb begin
    hsum  = {1'b0, acc_r, 1'b0} + (qbit ? {2'b0, mul_r} : {(WIDTH+2){1'b0}});
    hsub1 = {1'b0, hsum} - {3'b0, mod_r};
    hsub2 = {1'b0, hsum} - {2'b0, mod_r, 1'b0};
    priority if (!hsub2[WIDTH+2]) begin
      acc_nxt = hsub2[WIDTH-1:0];
    end else if (!hsub1[WIDTH+2]) begin
      acc_nxt = hsub1[WIDTH-1:0];
    end else begin
      acc_nxt = hsum[WIDTH-1:0];
    end
  end

  assign last = (cnt_r == CW'(WIDTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      mul_r <= mult;
      mod_r <= modulus;
      rem_r <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[WIDTH-1:0], 1'b0};
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

>>> src/modular_inverse_ext_euclid_core.sv
// top level of the modular inverse core: sequencer, euclid registers, result register
// uses mie_pkg, mie_in_if, mie_out_if and mie_div_unit
`timescale 1ns / 1ps
`default_nettype none

// Computes the inverse of value modulo modulus by the extended Euclidean
// algorithm, one item at a time. A negative value is first raised into
// 0..modulus-1; a non-negative value is used as given. The result gives
// invertible, the inverse in 0..modulus-1 and (modulus - inverse) mod modulus;
// both numbers are 0 when no inverse exists or modulus is 0. Each division
// runs on one bit-serial divider that also builds the quotient-times-coefficient
// product mod modulus as it goes. Each Euclid step is one division, and raising
// a negative value takes one more. in_ch.ready is high only when the core is
// idle; a finished result waits in the output register and the next item is
// taken meanwhile.
module modular_inverse_ext_euclid_core #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mie_in_if.sink    in_ch,
  mie_out_if.source out_ch
);

  mie_pkg::mie_state_t state_r, state_nxt;

  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] a3_r, a3_nxt;
  logic [WIDTH-1:0] b3_r, b3_nxt;
  logic [WIDTH-1:0] a2_r, a2_nxt;
  logic [WIDTH-1:0] b2_r, b2_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_inv_ok_r, out_inv_ok_nxt;
  logic [WIDTH-1:0] out_inverse_r, out_inverse_nxt;
  logic [WIDTH-1:0] out_neg_r, out_neg_nxt;

  logic             div_start;
  logic [WIDTH:0]   div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic [WIDTH-1:0] div_mult;
  logic [WIDTH-1:0] div_modulus;
  logic             div_done;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH-1:0] div_acc;

  logic             in_fire;
  logic [WIDTH:0]   neg_mag;
  logic [WIDTH-1:0] one_mod_in;
  logic [WIDTH-1:0] one_mod_r;

  assign in_fire    = in_ch.valid && (state_r == mie_pkg::ST_IDLE);
  assign neg_mag    = ~in_ch.value + (WIDTH+1)'(1);
  assign one_mod_in = (in_ch.modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign one_mod_r  = (m_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  mie_div_unit #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .mult     (div_mult),
    .modulus  (div_modulus),
    .done     (div_done),
    .rem      (div_rem),
    .acc      (div_acc)
  );

  always_comb begin
    state_nxt       = state_r;
    m_nxt           = m_r;
    a3_nxt          = a3_r;
    b3_nxt          = b3_r;
    a2_nxt          = a2_r;
    b2_nxt          = b2_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_inv_ok_nxt  = out_inv_ok_r;
    out_inverse_nxt = out_inverse_r;
    out_neg_nxt     = out_neg_r;
    div_start       = 1'b0;
    div_dividend    = {1'b0, a3_r};
    div_divisor     = b3_r;
    div_mult        = b2_r;
    div_modulus     = m_r;

    unique case (state_r)
      mie_pkg::ST_IDLE: begin
        if (in_fire) begin
          m_nxt = in_ch.modulus;
          if (in_ch.modulus == '0) begin
            // no inverse: b3 of zero makes the finish step give zeros
            b3_nxt    = '0;
            state_nxt = mie_pkg::ST_FINISH;
          end else if (in_ch.value[WIDTH]) begin
            // negative value: reduce its magnitude first
            div_start    = 1'b1;
            div_dividend = neg_mag;
            div_divisor  = in_ch.modulus;
            div_mult     = '0;
            div_modulus  = in_ch.modulus;
            state_nxt    = mie_pkg::ST_PREP;
          end else begin
            a3_nxt    = in_ch.modulus;
            b3_nxt    = in_ch.value[WIDTH-1:0];
            a2_nxt    = '0;
            b2_nxt    = one_mod_in;
            state_nxt = mie_pkg::ST_CHECK;
          end
        end
      end
      mie_pkg::ST_PREP: begin
        if (div_done) begin
          a3_nxt    = m_r;
          b3_nxt    = (div_rem == '0) ? '0 : m_r - div_rem;
          a2_nxt    = '0;
          b2_nxt    = one_mod_r;
          state_nxt = mie_pkg::ST_CHECK;
        end
      end
      mie_pkg::ST_CHECK: begin
        if (b3_r > WIDTH'(1)) begin
          div_start = 1'b1;
          state_nxt = mie_pkg::ST_DIV;
        end else begin
          state_nxt = mie_pkg::ST_FINISH;
        end
      end
      mie_pkg::ST_DIV: begin
        if (div_done) begin
          a3_nxt = b3_r;
          b3_nxt = div_rem;
          a2_nxt = b2_r;
          // (a2 - q*b2) mod m; the wrap of the w-bit sum lands in range
          b2_nxt = (a2_r >= div_acc) ? a2_r - div_acc : a2_r - div_acc + m_r;
          state_nxt = mie_pkg::ST_CHECK;
        end
      end
      mie_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (b3_r == WIDTH'(1)) begin
            out_inv_ok_nxt  = 1'b1;
            out_inverse_nxt = b2_r;
            out_neg_nxt     = (b2_r == '0) ? '0 : m_r - b2_r;
          end else begin
            out_inv_ok_nxt  = 1'b0;
            out_inverse_nxt = '0;
            out_neg_nxt     = '0;
          end
          state_nxt = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mie_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mie_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r           <= m_nxt;
    a3_r          <= a3_nxt;
    b3_r          <= b3_nxt;
    a2_r          <= a2_nxt;
    b2_r          <= b2_nxt;
    out_inv_ok_r  <= out_inv_ok_nxt;
    out_inverse_r <= out_inverse_nxt;
    out_neg_r     <= out_neg_nxt;
  end

  assign in_ch.ready            = (state_r == mie_pkg::ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.invertible      = out_inv_ok_r;
  assign out_ch.inverse         = out_inverse_r;
  assign out_ch.negated_inverse = out_neg_r;

endmodule

`default_nettype wire

>>> verif/modular_inverse_ext_euclid_core_checker.sv
// checker for the modular inverse core: watches both channels, predicts each inverse
// and compares it field by field; depends on mie_pkg, mie_in_if and mie_out_if
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_core_checker #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mie_in_if           in_mon,
  mie_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned inverses_pending
);

  typedef struct packed {
    logic             invertible;
    logic [WIDTH-1:0] inverse;
    logic [WIDTH-1:0] negated_inverse;
  } inv_result_t;

  inv_result_t inverse_q[$];

  // extended euclid on (m, n), coefficient of n kept mod m
  function automatic inv_result_t solve_inverse(logic [WIDTH-1:0] m_in,
                                                logic [WIDTH:0] v_in);
    logic [63:0]  m, n, mag, r, a3, b3, a2, b2, q, t3, t2, qb, neg;
    logic [WIDTH:0] neg_v;
    inv_result_t  res;
    res = '0;
    m = 64'(m_in);
    if (m == 0) return res;
    if (v_in[WIDTH]) begin
      neg_v = ~v_in + 1'b1;
      mag = 64'(neg_v);
      r = mag % m;
      n = (r == 0) ? 64'd0 : m - r;
    end else begin
      n = 64'(v_in);
    end
    a3 = m;
    b3 = n;
    a2 = 64'd0;
    b2 = 64'd1 % m;
    while (b3 > 1) begin
      q  = a3 / b3;
      t3 = b3;
      t2 = b2;
      b3 = a3 - q * b3;
      qb = 64'((128'(q % m) * 128'(b2)) % 128'(m));
      b2 = (a2 >= qb) ? a2 - qb : a2 + (m - qb);
      a3 = t3;
      a2 = t2;
    end
    if (b3 != 1) return res;
    neg = (b2 == 0) ? 64'd0 : m - b2;
    res.invertible      = 1'b1;
    res.inverse         = b2[WIDTH-1:0];
    res.negated_inverse = neg[WIDTH-1:0];
    return res;
  endfunction

  initial begin
    mismatch_count   = 0;
    inverses_pending = 0;
  end

  always @(posedge clk) begin
    inv_result_t want;
    if (rst_n) begin
      // results first, so a result never meets the item taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (inverse_q.size() == 0) begin
          $error("result item with no item outstanding");
          mismatch_count++;
        end else begin
          want = inverse_q.pop_front();
          if (out_mon.invertible !== want.invertible) begin
            $error("invertible: expected %0d, got %0d", want.invertible, out_mon.invertible);
            mismatch_count++;
          end
          if (out_mon.inverse !== want.inverse) begin
            $error("inverse: expected %0d, got %0d", want.inverse, out_mon.inverse);
            mismatch_count++;
          end
          if (out_mon.negated_inverse !== want.negated_inverse) begin
            $error("negated_inverse: expected %0d, got %0d", want.negated_inverse,
                   out_mon.negated_inverse);
            mismatch_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        inverse_q.push_back(solve_inverse(in_mon.modulus, in_mon.value));
      inverses_pending = inverse_q.size();
    end
  end

endmodule

>>> verif/modular_inverse_ext_euclid_core_test.sv
// testbench top for the modular inverse core: clock, reset, operand and ready stimulus, verdict
// depends on mie_pkg, mie_in_if, mie_out_if, the core and its checker
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_core_test;

  localparam int unsigned W = mie_pkg::WIDTH_DEF;

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned inverses_pending;
  int unsigned results_taken;

  mie_in_if  #(.WIDTH(W)) in_ch ();
  mie_out_if #(.WIDTH(W)) out_ch ();

  modular_inverse_ext_euclid_core #(.WIDTH(W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  modular_inverse_ext_euclid_core_checker #(.WIDTH(W)) inv_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count   (mismatch_count),
    .inverses_pending (inverses_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("modular_inverse_ext_euclid_core_test: done, errors");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  task automatic send_operands(input logic [W-1:0] m, input logic signed [W:0] v,
                               input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.modulus <= m;
    in_ch.value   <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pick_operands(output logic [W-1:0] m, output logic signed [W:0] v);
    int unsigned kind;
    int unsigned k;
    int          small_v;
    logic [63:0] f_prev, f_cur, f_next;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      m = $urandom;
      v = {1'($urandom_range(0, 1)), 32'($urandom)};
    end else if (kind < 55) begin
      // value below the modulus, either sign
      m = $urandom;
      v = (m == 0) ? '0 : (W+1)'($urandom % m);
      if ($urandom_range(0, 3) == 0) v = -v;
    end else if (kind < 70) begin
      m = $urandom_range(1, 200);
      small_v = $urandom_range(0, 1000);
      small_v = small_v - 500;
      v = (W+1)'(small_v);
    end else if (kind < 82) begin
      case ($urandom_range(0, 5))
        0: m = 32'd4294967291;
        1: m = 32'd2147483647;
        2: m = 32'd65521;
        3: m = 32'd1000003;
        4: m = 32'd97;
        default: m = 32'd3;
      endcase
      v = {1'b0, 32'($urandom)};
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (kind < 92) begin
      // neighbouring fibonacci numbers drive the longest euclid runs
      k = $urandom_range(2, 47);
      f_prev = 64'd0;
      f_cur  = 64'd1;
      repeat (k - 1) begin
        f_next = f_prev + f_cur;
        f_prev = f_cur;
        f_cur  = f_next;
      end
      m = f_cur[W-1:0];
      v = {1'b0, f_prev[W-1:0]};
      if ($urandom_range(0, 2) == 0) v = -v;
    end else begin
      // whole multiples of the modulus, never invertible unless m is one
      m = $urandom_range(1, 100000);
      v = (W+1)'(64'(m) * 64'($urandom_range(0, 40000)));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
  endtask

  // receiver: one cycle of ready, counting taken result items
  task automatic take_cycle(input bit rdy);
    out_ch.ready <= rdy;
    @(posedge clk);
    if (out_ch.valid && out_ch.ready) results_taken++;
  endtask

  initial begin
    int unsigned next_hold;
    int unsigned r;
    int unsigned len;
    results_taken = 0;
    next_hold     = 40;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (results_taken >= next_hold) begin
        // long hold-off so the core fills and drops in_ch.ready
        next_hold = (next_hold == 40) ? 250 : 32'hFFFF_FFFF;
        repeat (4000) take_cycle(1'b0);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          len = $urandom_range(20, 200);
          repeat (len) take_cycle(1'b1);
        end else if (r < 9) begin
          len = $urandom_range(10, 100);
          repeat (len) take_cycle($urandom_range(0, 2) != 0);
        end else begin
          len = $urandom_range(50, 400);
          repeat (len) take_cycle(1'b0);
        end
      end
    end
  end

  initial begin
    logic [W-1:0]        m;
    logic signed [W:0]   v;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.modulus <= '0;
    in_ch.value   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // modulus of one, modulus zero, zero value, negative values, values at or above the modulus
    send_operands(32'd1, 33'sd0, 1'b0);
    send_operands(32'd1, 33'sd5, 1'b0);
    send_operands(32'd1, -33'sd3, 1'b0);
    send_operands(32'd0, 33'sd7, 1'b0);
    send_operands(32'd0, -33'sd1, 1'b0);
    send_operands(32'd7, 33'sd0, 1'b0);
    send_operands(32'd7, 33'sd3, 1'b0);
    send_operands(32'd7, -33'sd3, 1'b0);
    send_operands(32'd7, 33'sd14, 1'b0);
    send_operands(32'd7, 33'sd8, 1'b0);
    send_operands(32'd12, 33'sd8, 1'b0);
    send_operands(32'd2, 33'sd1, 1'b0);
    send_operands(32'd2, -33'sd1, 1'b0);
    send_operands(32'd10, -33'sd1, 1'b0);
    send_operands(32'hFFFF_FFFF, 33'sd4294967294, 1'b0);
    send_operands(32'hFFFF_FFFF, -33'sd4294967295, 1'b0);
    send_operands(32'hFFFF_FFFF, 33'sd4294967295, 1'b0);
    // most negative value the field holds
    send_operands(32'd3, 33'h1_0000_0000, 1'b0);
    send_operands(32'd4294967291, -33'sd1, 1'b0);
    send_operands(32'd4294967291, 33'sd2, 1'b0);
    // worst-case euclid run
    send_operands(32'd2971215073, 33'sd1836311903, 1'b0);
    send_operands(32'd2971215073, -33'sd1836311903, 1'b0);

    for (int i = 0; i < 370; i++) begin
      pick_operands(m, v);
      send_operands(m, v, (i % 50) < 15);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (inverses_pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("modular_inverse_ext_euclid_core_test: done, clean");
    end else begin
      $display("modular_inverse_ext_euclid_core_test: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/mie_pkg.sv
src/mie_in_if.sv
src/mie_out_if.sv
src/mie_div_unit.sv
src/modular_inverse_ext_euclid_core.sv
verif/modular_inverse_ext_euclid_core_checker.sv
verif/modular_inverse_ext_euclid_core_test.sv
